/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps

package tcw_pkg;

	// Default screen geometry
	localparam int COLS_DEFAULT = 80;
	localparam int ROWS_DEFAULT = 25;

	// Character codes with special meaning
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'd32;
	localparam logic [7:0] CH_NUL       = 8'd0;

	// Attribute after reset
	localparam logic [7:0] ATTR_RESET = 8'd7;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} tcw_op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_CLEAR,
		ST_FINISH
	} tcw_state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} tcw_req_t;

	typedef struct packed {
		logic [10:0] cursor_position;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
	} tcw_rsp_t;

endpackage

/* rtl/text_console_writer.sv */
`timescale 1ns / 1ps
// A put, read or undefined request moves to the finish state, which loads the response register.
// A scroll or clear first makes one pass over every cell of the cell RAM.
// No request is taken while busy, that is, outside the idle state.
// Reset (arst_n low, asynchronous): cursor homed, attribute 7, then a blanking pass over
// every cell of the cell RAM during which no request is accepted.
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLS = COLS_DEFAULT,
	parameter int ROWS = ROWS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  tcw_req_t   req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output tcw_rsp_t   rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int CELLS = COLS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = AW + 1;
	localparam int CLW   = $clog2(COLS);
	localparam int RW    = $clog2(ROWS);
	localparam int IW    = (AW > 11) ? AW + 1 : 12;

	localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);
	localparam logic [CLW-1:0] COL_LAST  = CLW'(COLS - 1);
	localparam logic [RW-1:0]  ROW_LAST  = RW'(ROWS - 1);

	tcw_state_t state_q, state_d;

	logic [7:0]     attr_q;
	logic [CLW-1:0] col_q, col_d;
	logic [RW-1:0]  row_q, row_d;
	logic [AW-1:0]  addr_q, addr_d;
	logic [AW-1:0]  idx_q, idx_d;
	logic           rd_ok_q, rd_ok_d;

	logic           wr_s1;
	logic [AW-1:0]  dst_s1;
	logic           from_ram_s1;

	logic           rsp_valid_q;
	tcw_rsp_t       rsp_q;
	logic           rsp_load;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [15:0]    ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [15:0]    ram_rdata;

	logic [AW-1:0]  add_op;
	logic [AW-1:0]  addr_sum;
	logic [AW-1:0]  col_ext;
	logic [SW-1:0]  src;
	logic           src_ok;
	logic           idx_ok;
	tcw_op_t        op;

	assign op       = tcw_op_t'(req.operation);
	assign col_ext  = AW'(col_q);
	assign addr_sum = addr_q + add_op;
	assign src      = SW'(idx_q) + SW'(COLS);
	assign src_ok   = src < SW'(CELLS);
	assign idx_ok   = IW'(req.cell_index) < IW'(CELLS);

	// Cell store: attribute in the upper byte, character in the lower
	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer: next state, cursor update and RAM control
	always_comb begin
		state_d   = state_q;
		col_d     = col_q;
		row_d     = row_q;
		addr_d    = addr_q;
		idx_d     = idx_q;
		rd_ok_d   = rd_ok_q;
		add_op    = '0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {attr_q, CH_SPACE};
		ram_re    = 1'b0;
		ram_raddr = src[AW-1:0];
		rsp_load  = 1'b0;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = {ATTR_RESET, CH_SPACE};
				if (idx_q == LAST_CELL) begin
					idx_d   = '0;
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					rd_ok_d = 1'b0;
					state_d = ST_FINISH;
					case (op)
						OP_PUT: begin
							if (req.char_code == CH_NEWLINE) begin
								col_d = '0;
								if (row_q == ROW_LAST) begin
									add_op  = '0 - col_ext;
									addr_d  = addr_sum;
									idx_d   = '0;
									state_d = ST_SCROLL;
								end else begin
									add_op = AW'(COLS) - col_ext;
									addr_d = addr_sum;
									row_d  = row_q + 1'b1;
								end
							end else if (req.char_code == CH_BACKSPACE) begin
								add_op = '1;
								if (col_q != '0 || row_q != '0) begin
									addr_d    = addr_sum;
									ram_we    = 1'b1;
									ram_waddr = addr_sum;
									ram_wdata = {attr_q, CH_NUL};
									if (col_q == '0) begin
										col_d = COL_LAST;
										row_d = row_q - 1'b1;
									end else begin
										col_d = col_q - 1'b1;
									end
								end
							end else begin
								ram_we    = 1'b1;
								ram_waddr = addr_q;
								ram_wdata = {attr_q, req.char_code};
								if (col_q == COL_LAST) begin
									col_d = '0;
									if (row_q == ROW_LAST) begin
										add_op  = '0 - col_ext;
										addr_d  = addr_sum;
										idx_d   = '0;
										state_d = ST_SCROLL;
									end else begin
										add_op = AW'(1);
										addr_d = addr_sum;
										row_d  = row_q + 1'b1;
									end
								end else begin
									add_op = AW'(1);
									addr_d = addr_sum;
									col_d  = col_q + 1'b1;
								end
							end
						end
						OP_CLEAR: begin
							col_d   = '0;
							row_d   = '0;
							addr_d  = '0;
							idx_d   = '0;
							state_d = ST_CLEAR;
						end
						OP_READ: begin
							if (idx_ok) begin
								ram_re    = 1'b1;
								ram_raddr = AW'(req.cell_index);
								rd_ok_d   = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCROLL: begin
				// Fetch the cell one row below, if any; its write follows in the next cycle
				ram_re = src_ok;
				if (idx_q == LAST_CELL) begin
					idx_d   = '0;
					state_d = ST_FINISH;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				if (idx_q == LAST_CELL) begin
					idx_d   = '0;
					state_d = ST_FINISH;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// Scroll write-back stage
		if (wr_s1) begin
			ram_we    = 1'b1;
			ram_waddr = dst_s1;
			ram_wdata = {attr_q, (from_ram_s1 ? ram_rdata[7:0] : CH_SPACE)};
		end
	end

	// State and cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			col_q   <= '0;
			row_q   <= '0;
			addr_q  <= '0;
			idx_q   <= '0;
			rd_ok_q <= 1'b0;
			wr_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			addr_q  <= addr_d;
			idx_q   <= idx_d;
			rd_ok_q <= rd_ok_d;
			wr_s1   <= (state_q == ST_SCROLL);
		end
	end

	// Scroll write-back payload
	always_ff @(posedge clk) begin
		dst_s1      <= idx_q;
		from_ram_s1 <= src_ok;
	end

	// Attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	// Response register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.cursor_position <= 11'(addr_q);
			rsp_q.cell_char       <= rd_ok_q ? ram_rdata[7:0] : 8'd0;
			rsp_q.cell_attr       <= rd_ok_q ? ram_rdata[15:8] : 8'd0;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A taken request makes the block busy on the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while a previous one is in progress");

	// Linear cursor address tracks row and column
	a_cursor_linear: assert property (@(posedge clk) disable iff (!arst_n)
		addr_q == AW'(int'(row_q) * COLS + int'(col_q)))
		else $error("cursor address out of step with row and column");

	// Cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) < COLS && int'(row_q) < ROWS)
		else $error("cursor off screen");

	// Scroll write-back runs only during the scroll walk and its finish step
	a_scroll_drain: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (state_q == ST_SCROLL || state_q == ST_FINISH))
		else $error("scroll write-back outside of scroll");

endmodule

/* rtl/tcw_ram.sv */
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* dv/text_console_writer_tb.sv */
`timescale 1ns / 1ps

import tcw_pkg::*;

// Shadow of the console: cell store, cursor and attribute, plus the responses still owed
class console_scoreboard;
	localparam int COLS  = COLS_DEFAULT;
	localparam int ROWS  = ROWS_DEFAULT;
	localparam int CELLS = COLS * ROWS;

	logic [7:0]  glyph [CELLS];
	logic [7:0]  shade [CELLS];
	int unsigned cur_col;
	int unsigned cur_row;
	logic [7:0]  text_attr;
	tcw_rsp_t    awaited [$];
	int unsigned mismatches;

	function new();
		text_attr = ATTR_RESET;
		blank_screen();
		cur_col = 0;
		cur_row = 0;
		mismatches = 0;
	endfunction

	function void blank_screen();
		for (int i = 0; i < CELLS; i++) begin
			glyph[i] = CH_SPACE;
			shade[i] = text_attr;
		end
	endfunction

	function void write_cell(logic [7:0] code);
		int unsigned at;
		at = cur_row * COLS + cur_col;
		glyph[at] = code;
		shade[at] = text_attr;
	endfunction

	// Move every row up one, repaint all attributes, blank the bottom row
	function void scroll_up();
		for (int i = 0; i < CELLS; i++) begin
			glyph[i] = (i + COLS < CELLS) ? glyph[i + COLS] : CH_SPACE;
			shade[i] = text_attr;
		end
		cur_col = 0;
	endfunction

	function void put_char(logic [7:0] code);
		if (code == CH_NEWLINE) begin
			if (cur_row == ROWS - 1) begin
				scroll_up();
			end else begin
				cur_row++;
				cur_col = 0;
			end
		end else if (code == CH_BACKSPACE) begin
			// nothing happens at the origin
			if (cur_col != 0 || cur_row != 0) begin
				if (cur_col == 0) begin
					cur_col = COLS - 1;
					cur_row--;
				end else begin
					cur_col--;
				end
				write_cell(CH_NUL);
			end
		end else begin
			write_cell(code);
			if (cur_col == COLS - 1) begin
				if (cur_row == ROWS - 1) begin
					scroll_up();
				end else begin
					cur_col = 0;
					cur_row++;
				end
			end else begin
				cur_col++;
			end
		end
	endfunction

	// Apply an accepted request and queue the response it must produce
	function void note_request(tcw_req_t r);
		tcw_rsp_t want;
		want = '0;
		case (tcw_op_t'(r.operation))
			OP_PUT: begin
				put_char(r.char_code);
			end
			OP_CLEAR: begin
				blank_screen();
				cur_col = 0;
				cur_row = 0;
			end
			OP_READ: begin
				if (r.cell_index < CELLS) begin
					want.cell_char = glyph[r.cell_index];
					want.cell_attr = shade[r.cell_index];
				end
			end
			default: begin
			end
		endcase
		want.cursor_position = 11'(cur_row * COLS + cur_col);
		awaited.push_back(want);
	endfunction

	// Compare a response with the oldest one owed
	function void check_result(tcw_rsp_t got);
		tcw_rsp_t want;
		if (awaited.size() == 0) begin
			$error("unexpected response: cursor_position %0d cell_char %0d cell_attr %0d",
				got.cursor_position, got.cell_char, got.cell_attr);
			mismatches++;
			return;
		end
		want = awaited.pop_front();
		if (got.cursor_position !== want.cursor_position) begin
			$error("cursor_position: expected %0d, got %0d",
				want.cursor_position, got.cursor_position);
			mismatches++;
		end
		if (got.cell_char !== want.cell_char) begin
			$error("cell_char: expected %0d, got %0d", want.cell_char, got.cell_char);
			mismatches++;
		end
		if (got.cell_attr !== want.cell_attr) begin
			$error("cell_attr: expected %0d, got %0d", want.cell_attr, got.cell_attr);
			mismatches++;
		end
	endfunction
endclass

module text_console_writer_tb;
	localparam int CELLS          = COLS_DEFAULT * ROWS_DEFAULT;
	localparam int SETTLE_CYCLES  = CELLS + 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_LENGTH   = 280;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	tcw_req_t    req;
	logic        rsp_valid;
	logic        rsp_stall;
	tcw_rsp_t    rsp;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;

	bit                calm;
	int unsigned       quiet_cycles = 0;
	console_scoreboard board;

	text_console_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic tcw_req_t make_req(tcw_op_t op, logic [7:0] code, logic [10:0] index);
		tcw_req_t r;
		r.operation  = op;
		r.char_code  = code;
		r.cell_index = index;
		return r;
	endfunction

	// Offer one request after an optional gap and hold it until taken
	task automatic send_request(input tcw_req_t r);
		int unsigned gap;
		gap = calm ? 0 : idle_length();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
	endtask

	task automatic wait_drained();
		while (board.awaited.size() != 0) @(posedge clk);
	endtask

	// Change the attribute only once the block has gone quiet
	task automatic set_attribute(input logic [7:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.text_attr = value;
	endtask

	// Random traffic: mostly text and line control, some reads, rare clears and undefined requests
	task automatic run_random(input int count);
		tcw_req_t    r;
		int unsigned pick;
		int unsigned here;
		for (int n = 0; n < count; n++) begin
			if (n % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			r = make_req(OP_PUT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
			pick = $urandom_range(0, 999);
			if (pick < 620) begin
			end else if (pick < 720) begin
				r.char_code = CH_NEWLINE;
			end else if (pick < 780) begin
				r.char_code = CH_BACKSPACE;
			end else if (pick < 980) begin
				r.operation = OP_READ;
				here = board.cur_row * COLS_DEFAULT + board.cur_col;
				case ($urandom_range(0, 2))
					0: r.cell_index = 11'((here >= 200) ? here - $urandom_range(0, 200)
						: $urandom_range(0, here));
					1: begin
					end
					default: r.cell_index = 11'($urandom_range(CELLS - COLS_DEFAULT, 2047));
				endcase
			end else if (pick < 984) begin
				r.operation = OP_CLEAR;
			end else begin
				r.operation = OP_NONE;
			end
			send_request(r);
		end
		req_valid <= 1'b0;
	endtask

	// Response side back-pressure
	initial begin
		int unsigned hold;
		rsp_stall <= 1'b0;
		@(posedge clk);
		forever begin
			hold = calm ? 0 : idle_length();
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Predict on each accepted request, check each accepted response
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			board.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_result(rsp);
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Abandon the run when nothing moves for too long
	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		board = new();
		calm = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reads of the blanked store, including past its end, then an undefined request
		send_request(make_req(OP_READ, 8'h00, 11'd0));
		send_request(make_req(OP_READ, 8'hFF, 11'(CELLS - 1)));
		send_request(make_req(OP_READ, 8'h00, 11'(CELLS)));
		send_request(make_req(OP_READ, 8'h00, 11'h7FF));
		send_request(make_req(OP_NONE, 8'hFF, 11'h7FF));
		// extreme characters, then back over them and past the origin
		send_request(make_req(OP_PUT, 8'h00, 11'h7FF));
		send_request(make_req(OP_PUT, 8'hFF, 11'd0));
		send_request(make_req(OP_PUT, CH_BACKSPACE, 11'd0));
		send_request(make_req(OP_PUT, CH_BACKSPACE, 11'd0));
		send_request(make_req(OP_PUT, CH_BACKSPACE, 11'd0));
		send_request(make_req(OP_READ, 8'h00, 11'd1));
		send_request(make_req(OP_READ, 8'h00, 11'd0));
		// backspace from column zero lands on the last column above
		send_request(make_req(OP_PUT, CH_NEWLINE, 11'd0));
		send_request(make_req(OP_PUT, CH_BACKSPACE, 11'd0));
		send_request(make_req(OP_READ, 8'h00, 11'(COLS_DEFAULT - 1)));
		// a character in the last column wraps to the next row
		send_request(make_req(OP_PUT, 8'h41, 11'd0));
		send_request(make_req(OP_READ, 8'h00, 11'(COLS_DEFAULT - 1)));
		send_request(make_req(OP_PUT, 8'h5A, 11'd0));
		send_request(make_req(OP_CLEAR, 8'h00, 11'd0));
		send_request(make_req(OP_READ, 8'h00, 11'(COLS_DEFAULT - 1)));
		send_request(make_req(OP_READ, 8'h00, 11'(COLS_DEFAULT)));
		send_request(make_req(OP_NONE, 8'h00, 11'd0));

		run_random(250);
		set_attribute(8'hFF);
		run_random(PHASE_LENGTH);
		set_attribute(8'h00);
		run_random(PHASE_LENGTH);
		repeat (3) begin
			set_attribute(8'($urandom_range(0, 255)));
			run_random(PHASE_LENGTH);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

/* files.f */
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer.sv
dv/text_console_writer_tb.sv
